[hw/rtl/text_console_with_scroll_macros.svh]
// Assertion macros shared by the text console modules
`ifndef TEXT_CONSOLE_WITH_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_WITH_SCROLL_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define TCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcs_pkg.sv]
// Shared types, codes and constants of the text console
package tcs_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int LOC_W     = 11;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Attribute after reset and the blank cell it gives
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  // Screen store operation selected by the controller
  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_INIT,
    MEM_CLEAR,
    MEM_COPY_RD,
    MEM_COPY_WR,
    MEM_BLANK
  } mem_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    take;
    logic    cnt_clr;
    logic    cnt_inc;
    mem_op_t mem;
    logic    capture;
    logic    load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                scroll_now;
    logic                cnt_at_end;
    logic                cnt_at_copy_end;
    logic                cnt_at_row_end;
  } sts_t;

endpackage

[hw/rtl/text_console_with_scroll.sv]
// Text console top level: a COLUMNS x ROWS screen of 16-bit cells with a cursor.
// Input stream: s_tuser carries the operation (put, clear, read), s_tdata the
// byte to put and the cell index to read. Every transfer in gives exactly one
// transfer out on m_tdata: cursor location, read cell (0 unless an in-range read) and a
// flag for a scroll. cfg_we writes the attribute used for new characters and blanks.
// A clear sweeps every cell of the screen store; a put that scrolls copies each
// row up by one and then blanks the last row. One item is in work at a time: a
// new transfer is taken only after the last result has been loaded for output.
// After reset a clearing pass writes every cell blank with attribute 0x0F, one
// cell a cycle, and s_tready stays low until that pass is done.
// A finished result is held in the output register while the receiver stalls;
// the next item is still taken and worked on, and waits only to deliver.
module text_console_with_scroll #(
  parameter int COLUMNS   = tcs_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcs_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcs_pkg::TAB_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Attribute register write
  input  logic                          cfg_we,
  input  logic [tcs_pkg::ATTR_W-1:0]    cfg_wdata,   // text_attribute
  // Operation stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tcs_pkg::S_TDATA_W-1:0] s_tdata,     // char_code[7:0], read_index[18:8]
  input  logic [tcs_pkg::OPCODE_W-1:0]  s_tuser,     // opcode[1:0]
  // Result stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcs_pkg::M_TDATA_W-1:0] m_tdata      // cursor_location[10:0],
                                                     // read_data[26:11], scrolled[27]
);

  tcs_pkg::cmd_t cmd;
  tcs_pkg::sts_t sts;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcs_dpath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

endmodule

[hw/rtl/tcs_ram.sv]
// Generic single-write, single-read RAM with registered read data
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tcs_ctrl.sv]
// Controller state machine of the text console
`include "text_console_with_scroll_macros.svh"

module tcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  tcs_pkg::sts_t sts,
  output tcs_pkg::cmd_t cmd
);

  tcs_pkg::state_t state;
  tcs_pkg::state_t state_next;
  logic            out_valid;
  logic            out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcs_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result valid until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcs_pkg::ST_INIT: begin
        if (sts.cnt_at_end) begin
          state_next = tcs_pkg::ST_IDLE;
        end
      end
      tcs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (sts.opcode)
            tcs_pkg::OP_PUT: begin
              state_next = sts.scroll_now ? tcs_pkg::ST_COPY_RD : tcs_pkg::ST_DONE;
            end
            tcs_pkg::OP_CLEAR: state_next = tcs_pkg::ST_CLEAR;
            tcs_pkg::OP_READ:  state_next = tcs_pkg::ST_READ;
            default:           state_next = tcs_pkg::ST_DONE;
          endcase
        end
      end
      tcs_pkg::ST_COPY_RD: state_next = tcs_pkg::ST_COPY_WR;
      tcs_pkg::ST_COPY_WR: begin
        state_next = sts.cnt_at_copy_end ? tcs_pkg::ST_BLANK : tcs_pkg::ST_COPY_RD;
      end
      tcs_pkg::ST_BLANK: begin
        if (sts.cnt_at_row_end) begin
          state_next = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_CLEAR: begin
        if (sts.cnt_at_end) begin
          state_next = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_READ: state_next = tcs_pkg::ST_DONE;
      tcs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tcs_pkg::ST_IDLE;
        end
      end
      default: state_next = tcs_pkg::ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.mem  = tcs_pkg::MEM_IDLE;
    s_tready = 1'b0;
    case (state)
      tcs_pkg::ST_INIT: begin
        cmd.mem     = tcs_pkg::MEM_INIT;
        cmd.cnt_inc = 1'b1;
      end
      tcs_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.take    = s_tvalid;
        cmd.cnt_clr = 1'b1;
      end
      tcs_pkg::ST_COPY_RD: cmd.mem = tcs_pkg::MEM_COPY_RD;
      tcs_pkg::ST_COPY_WR: begin
        cmd.mem     = tcs_pkg::MEM_COPY_WR;
        cmd.cnt_clr = sts.cnt_at_copy_end;
        cmd.cnt_inc = !sts.cnt_at_copy_end;
      end
      tcs_pkg::ST_BLANK: begin
        cmd.mem     = tcs_pkg::MEM_BLANK;
        cmd.cnt_inc = 1'b1;
      end
      tcs_pkg::ST_CLEAR: begin
        cmd.mem     = tcs_pkg::MEM_CLEAR;
        cmd.cnt_inc = 1'b1;
      end
      tcs_pkg::ST_READ: cmd.capture = 1'b1;
      tcs_pkg::ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  `TCS_ASSERT_SAME(a_load_when_free, cmd.load_out, !out_valid || m_tready,
    "result loaded over an untaken result")
  `TCS_ASSERT_NEXT(a_clear_walks, cmd.take && sts.opcode == tcs_pkg::OP_CLEAR,
    state == tcs_pkg::ST_CLEAR, "clear did not start its sweep")
  `TCS_ASSERT_SAME(a_copy_order, state == tcs_pkg::ST_COPY_WR,
    $past(state) == tcs_pkg::ST_COPY_RD, "scroll write without its read")

endmodule

[hw/rtl/tcs_dpath.sv]
// Datapath of the text console: cursor, attribute, screen store and result
`include "text_console_with_scroll_macros.svh"

module tcs_dpath #(
  parameter int COLUMNS   = tcs_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcs_pkg::ROWS_DEF,
  parameter int TAB_WIDTH = tcs_pkg::TAB_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcs_pkg::ATTR_W-1:0]      cfg_wdata,
  input  logic [tcs_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [tcs_pkg::OPCODE_W-1:0]    s_tuser,
  input  tcs_pkg::cmd_t                   cmd,
  output tcs_pkg::sts_t                   sts,
  output logic [tcs_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int NCOL_W     = $clog2(COLUMNS + TAB_WIDTH);
  localparam int MAX_STOPS  = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int BLANK_BASE = (ROWS - 1) * COLUMNS;
  localparam int CMP_W      = ((ADDR_W > tcs_pkg::INDEX_W) ? ADDR_W : tcs_pkg::INDEX_W) + 1;
  localparam int PAD_W      = tcs_pkg::M_TDATA_W - tcs_pkg::LOC_W - tcs_pkg::CELL_W - 1;

  logic [tcs_pkg::CHAR_W-1:0]  ch;
  logic [tcs_pkg::INDEX_W-1:0] read_index;

  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;
  logic [tcs_pkg::ATTR_W-1:0]  attr;
  logic [ADDR_W-1:0]           cnt;
  logic                        rd_ok;
  logic                        res_scr;
  logic [tcs_pkg::CELL_W-1:0]  res_data;
  logic [tcs_pkg::LOC_W-1:0]   out_loc;
  logic [tcs_pkg::CELL_W-1:0]  out_data;
  logic                        out_scr;

  logic [ADDR_W-1:0]           cur_idx;
  logic [NCOL_W-1:0]           tab_col;
  logic [NCOL_W-1:0]           col_n;
  logic [ROW_W:0]              row_n;
  logic [COL_W-1:0]            col_next;
  logic [ROW_W-1:0]            row_next;
  logic                        printable;
  logic                        scroll_now;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [tcs_pkg::CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [tcs_pkg::CELL_W-1:0]  ram_rdata;
  logic [tcs_pkg::CELL_W-1:0]  blank;

  assign ch         = s_tdata[tcs_pkg::CHAR_W-1:0];
  assign read_index = s_tdata[tcs_pkg::CHAR_W +: tcs_pkg::INDEX_W];
  assign blank      = {attr, tcs_pkg::CH_SPACE};
  assign cur_idx    = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  assign printable  = !ch[tcs_pkg::CHAR_W-1] && (ch >= tcs_pkg::CH_SPACE);

  // Next tab stop: smallest multiple of the tab width above the column
  always_comb begin
    tab_col = NCOL_W'(MAX_STOPS * TAB_WIDTH);
    for (int k = MAX_STOPS; k >= 1; k--) begin
      if (k * TAB_WIDTH > int'(col)) begin
        tab_col = NCOL_W'(k * TAB_WIDTH);
      end
    end
  end

  // Cursor motion for a put, then right-edge wrap and bottom-edge scroll
  always_comb begin
    col_n = NCOL_W'(col);
    row_n = {1'b0, row};
    if (!ch[tcs_pkg::CHAR_W-1]) begin
      case (ch)
        tcs_pkg::CH_BS: begin
          if (col != '0) begin
            col_n = NCOL_W'(col) - NCOL_W'(1);
          end
        end
        tcs_pkg::CH_TAB: col_n = tab_col;
        tcs_pkg::CH_CR:  col_n = '0;
        tcs_pkg::CH_LF: begin
          col_n = '0;
          row_n = row_n + (ROW_W+1)'(1);
        end
        default: begin
          if (printable) begin
            col_n = NCOL_W'(col) + NCOL_W'(1);
          end
        end
      endcase
    end
    if (col_n >= NCOL_W'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + (ROW_W+1)'(1);
    end
    scroll_now = row_n >= (ROW_W+1)'(ROWS);
    col_next   = COL_W'(col_n);
    row_next   = scroll_now ? ROW_W'(ROWS - 1) : ROW_W'(row_n);
  end

  // Cursor update on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.take) begin
      if (s_tuser == tcs_pkg::OP_PUT) begin
        col <= col_next;
        row <= row_next;
      end else if (s_tuser == tcs_pkg::OP_CLEAR) begin
        col <= '0;
        row <= '0;
      end
    end
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcs_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  // Sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + ADDR_W'(1);
    end
  end

  // Per-item result state
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_scr  <= (s_tuser == tcs_pkg::OP_PUT) && scroll_now;
      res_data <= '0;
      rd_ok    <= CMP_W'(read_index) < CMP_W'(CELLS);
    end else if (cmd.capture && rd_ok) begin
      res_data <= ram_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_loc  <= tcs_pkg::LOC_W'(cur_idx);
      out_data <= res_data;
      out_scr  <= res_scr;
    end
  end

  assign m_tdata = {PAD_W'(0), out_scr, out_data, out_loc};

  // Screen store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = blank;
    ram_raddr = cnt + ADDR_W'(COLUMNS);
    case (cmd.mem)
      tcs_pkg::MEM_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcs_pkg::RESET_CELL;
      end
      tcs_pkg::MEM_CLEAR: ram_we = 1'b1;
      tcs_pkg::MEM_COPY_RD: ram_raddr = cnt + ADDR_W'(COLUMNS);
      tcs_pkg::MEM_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tcs_pkg::MEM_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(BLANK_BASE) + cnt;
      end
      default: begin
        ram_raddr = ADDR_W'(read_index);
        ram_waddr = cur_idx;
        ram_wdata = {attr, ch};
        ram_we    = cmd.take && (s_tuser == tcs_pkg::OP_PUT) && printable;
      end
    endcase
  end

  tcs_ram #(
    .WIDTH (tcs_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  always_comb begin
    sts                 = '0;
    sts.opcode          = s_tuser;
    sts.scroll_now      = scroll_now;
    sts.cnt_at_end      = cnt == ADDR_W'(CELLS - 1);
    sts.cnt_at_copy_end = cnt == ADDR_W'(BLANK_BASE - 1);
    sts.cnt_at_row_end  = cnt == ADDR_W'(COLUMNS - 1);
  end

  `TCS_ASSERT_SAME(a_cursor_range, 1'b1,
    (int'(row) < ROWS) && (int'(col) < COLUMNS), "cursor left the screen")
  `TCS_ASSERT_SAME(a_scroll_row, cmd.load_out && res_scr, row == ROW_W'(ROWS - 1),
    "scroll result without cursor on the last row")

endmodule
